/* design/fcdma_pkg.sv */
package fcdma_pkg;

	localparam int FIFO_BURST_WORDS = 4;
	localparam int BurstW = $clog2(FIFO_BURST_WORDS + 1);

	typedef enum logic [2:0] {
		CMD_WRITE  = 3'd0,
		CMD_READ   = 3'd1,
		CMD_POLL   = 3'd2,
		CMD_VBLANK = 3'd3,
		CMD_HBLANK = 3'd4,
		CMD_FIFO   = 3'd5,
		CMD_TICK   = 3'd6,
		CMD_NONE   = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		REG_SRC  = 2'd0,
		REG_DST  = 2'd1,
		REG_CNT  = 2'd2,
		REG_CTL  = 2'd3
	} reg_t;

	localparam int CTL_ENABLE = 15;
	localparam int CTL_IRQ    = 14;
	localparam int CTL_WORD   = 10;
	localparam int CTL_REPEAT = 9;

	localparam logic [1:0] TIM_IMM   = 2'd0;
	localparam logic [1:0] TIM_VBL   = 2'd1;
	localparam logic [1:0] TIM_HBL   = 2'd2;
	localparam logic [1:0] TIM_FIFO  = 2'd3;
	localparam logic [1:0] STEP_UP   = 2'd0;
	localparam logic [1:0] STEP_DOWN = 2'd1;
	localparam logic [1:0] STEP_NOWB = 2'd3;

	typedef struct packed {
		logic [2:0]  command;
		logic [1:0]  channel_sel;
		logic [1:0]  register_sel;
		logic [31:0] write_value;
		logic [31:0] fifo_address;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] read_value;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic        word_unit;
		logic [1:0]  unit_channel;
		logic        last_unit;
		logic        irq_raise;
	} rsp_t;

endpackage

/* design/fcdma_if.sv */
interface fcdma_req_if;
	logic                valid;
	logic                ready;
	fcdma_pkg::req_t     payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface fcdma_rsp_if;
	logic                valid;
	logic                ready;
	fcdma_pkg::rsp_t     payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

/* design/four_channel_dma_controller_core.sv */
// channel | role   | payload
// req     | sink   | command, channel_sel, register_sel, write_value, fifo_address
// rsp     | source | kind, read_value, source_address, dest_address, word_unit, ...
//
// One request per cycle unless stalled; a read or tick result is registered in the
// result register. All channel state updates in the cycle the request is taken.
// arst_n clears all registers but the result payload, and the queue; no channel is in service.
// A full result register that is not taken stalls new requests only.
module four_channel_dma_controller_core (
	input logic clk,
	input logic arst_n,
	fcdma_req_if.sink   req,
	fcdma_rsp_if.source rsp
);
	logic            go, has_rsp;
	fcdma_pkg::rsp_t res;
	logic            full_q;
	fcdma_pkg::rsp_t out_q;

	assign req.ready = !full_q || rsp.ready;
	assign go = req.valid && req.ready;

	fcdma_engine u_engine (
		.clk(clk), .arst_n(arst_n), .go(go), .req(req.payload),
		.has_rsp(has_rsp), .rsp(res)
	);

	// hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) full_q <= 1'b0;
		else if (req.ready) full_q <= go && has_rsp;
	end
	always_ff @(posedge clk) begin
		if (go && has_rsp) out_q <= res;
	end

	assign rsp.valid = full_q;
	assign rsp.payload = out_q;
endmodule

/* design/fcdma_engine.sv */
module fcdma_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  fcdma_pkg::req_t req,
	output logic            has_rsp,
	output fcdma_pkg::rsp_t rsp
);
	logic [31:0] src_q [4];
	logic [31:0] dst_q [4];
	logic [15:0] cnt_q [4];
	logic [15:0] ctl_q [4];
	logic [3:0]  imm_done_q;
	logic [1:0]  latched_q;
	logic [31:0] fptr_q [2];
	logic [fcdma_pkg::BurstW-1:0] fleft_q [2];
	logic [3:0]  pend_q;
	logic        act_q;
	logic [1:0]  ach_q;
	logic [31:0] cur_src_q, cur_dst_q;
	logic [16:0] left_q;

	logic [31:0] src_d [4];
	logic [31:0] dst_d [4];
	logic [15:0] ctl_d [4];
	logic [3:0]  imm_done_d;
	logic [1:0]  latched_d;
	logic [31:0] fptr_d [2];
	logic [fcdma_pkg::BurstW-1:0] fleft_d [2];
	logic [3:0]  pend_d;
	logic        act_d;
	logic [1:0]  ach_d;
	logic [31:0] cur_src_d, cur_dst_d;
	logic [16:0] left_d;

	// next state and result for one request
	always_comb begin
		logic [1:0]  ch;
		logic [15:0] ctl;
		logic [31:0] unit, s, d;
		logic [1:0]  ss, ds;
		logic        busy, fifo_run;
		logic [16:0] lft;
		logic [13:0] c14;
		for (int i = 0; i < 4; i++) begin
			src_d[i] = src_q[i];
			dst_d[i] = dst_q[i];
			ctl_d[i] = ctl_q[i];
		end
		for (int i = 0; i < 2; i++) begin
			fptr_d[i] = fptr_q[i];
			fleft_d[i] = fleft_q[i];
		end
		imm_done_d = imm_done_q;
		latched_d = latched_q;
		pend_d = pend_q;
		act_d = act_q;
		ach_d = ach_q;
		cur_src_d = cur_src_q;
		cur_dst_d = cur_dst_q;
		left_d = left_q;
		has_rsp = 1'b0;
		rsp = '0;
		ch = req.channel_sel;
		ctl = '0; unit = '0; s = '0; d = '0; ss = '0; ds = '0;
		busy = 1'b0; fifo_run = 1'b0; lft = '0; c14 = '0;
		if (go) begin
			case (fcdma_pkg::cmd_t'(req.command))
				fcdma_pkg::CMD_WRITE: begin
					case (fcdma_pkg::reg_t'(req.register_sel))
						fcdma_pkg::REG_SRC: src_d[ch] = req.write_value;
						fcdma_pkg::REG_DST: dst_d[ch] = req.write_value;
						fcdma_pkg::REG_CNT: ;
						default: begin
							ctl_d[ch] = req.write_value[15:0];
							if (!req.write_value[fcdma_pkg::CTL_ENABLE]) begin
								imm_done_d[ch] = 1'b0;
								if (ch == 2'd1) latched_d[0] = 1'b0;
								if (ch == 2'd2) latched_d[1] = 1'b0;
							end
						end
					endcase
				end
				fcdma_pkg::CMD_READ: begin
					has_rsp = 1'b1;
					case (fcdma_pkg::reg_t'(req.register_sel))
						fcdma_pkg::REG_SRC: rsp.read_value = src_q[ch];
						fcdma_pkg::REG_DST: rsp.read_value = dst_q[ch];
						fcdma_pkg::REG_CNT: rsp.read_value = {16'd0, cnt_q[ch]};
						default:            rsp.read_value = {16'd0, ctl_q[ch]};
					endcase
				end
				fcdma_pkg::CMD_POLL: begin
					for (int i = 0; i < 4; i++) begin
						if (!ctl_q[i][fcdma_pkg::CTL_ENABLE]) begin
							imm_done_d[i] = 1'b0;
							if (i == 1 || i == 2) latched_d[i-1] = 1'b0;
						end else begin
							if ((i == 1 || i == 2) && ctl_q[i][13:12] == fcdma_pkg::TIM_FIFO
									&& !latched_q[i-1]) begin
								fptr_d[i-1] = src_q[i];
								latched_d[i-1] = 1'b1;
							end
							if (!imm_done_q[i] && ctl_q[i][13:12] == fcdma_pkg::TIM_IMM) begin
								if (!(act_q && ach_q == 2'(i))) pend_d[i] = 1'b1;
								imm_done_d[i] = 1'b1;
							end
						end
					end
				end
				fcdma_pkg::CMD_VBLANK, fcdma_pkg::CMD_HBLANK: begin
					for (int i = 0; i < 4; i++)
						if (ctl_q[i][fcdma_pkg::CTL_ENABLE] && ctl_q[i][13:12] ==
								((req.command == fcdma_pkg::CMD_VBLANK) ?
								fcdma_pkg::TIM_VBL : fcdma_pkg::TIM_HBL)
								&& !(act_q && ach_q == 2'(i)))
							pend_d[i] = 1'b1;
				end
				fcdma_pkg::CMD_FIFO: begin
					for (int i = 1; i <= 2; i++) begin
						if (!ctl_q[i][fcdma_pkg::CTL_ENABLE]
								|| ctl_q[i][13:12] != fcdma_pkg::TIM_FIFO)
							latched_d[i-1] = 1'b0;
						else if (dst_q[i] == req.fifo_address) begin
							if (!latched_q[i-1]) begin
								fptr_d[i-1] = src_q[i];
								latched_d[i-1] = 1'b1;
							end
							if (!pend_q[i] && !(act_q && ach_q == 2'(i))) begin
								fleft_d[i-1] = fcdma_pkg::BurstW'(fcdma_pkg::FIFO_BURST_WORDS);
								pend_d[i] = 1'b1;
							end
						end
					end
				end
				fcdma_pkg::CMD_TICK: begin
					busy = act_q || (pend_q != 4'd0);
					ch = ach_q;
					lft = left_q;
					s = cur_src_q;
					d = cur_dst_q;
					if (!act_q) begin
						ch = pend_q[0] ? 2'd0 : pend_q[1] ? 2'd1 : pend_q[2] ? 2'd2 : 2'd3;
						pend_d[ch] = 1'b0;
						if (!((ch == 2'd1 && fleft_q[0] != '0)
								|| (ch == 2'd2 && fleft_q[1] != '0))) begin
							c14 = cnt_q[ch][13:0];
							if (ch == 2'd3)
								lft = (cnt_q[3] != '0) ? {1'b0, cnt_q[3]} : 17'h10000;
							else
								lft = (c14 != '0) ? {3'd0, c14} : 17'h4000;
							s = src_q[ch];
							d = dst_q[ch];
						end else
							lft = '0;
					end
					fifo_run = (ch == 2'd1 && fleft_q[0] != '0)
						|| (ch == 2'd2 && fleft_q[1] != '0);
					if (busy) begin
						has_rsp = 1'b1;
						rsp.kind = 1'b1;
						rsp.unit_channel = ch;
						act_d = 1'b1;
						ach_d = ch;
						if (fifo_run) begin
							rsp.source_address = fptr_q[ch[1]];
							rsp.dest_address = dst_q[ch];
							rsp.word_unit = 1'b1;
							fptr_d[ch[1]] = fptr_q[ch[1]] + 32'd4;
							fleft_d[ch[1]] = fleft_q[ch[1]] - 1'b1;
							if (fleft_q[ch[1]] == fcdma_pkg::BurstW'(1)) begin
								rsp.last_unit = 1'b1;
								act_d = 1'b0;
							end
						end else begin
							ctl = ctl_q[ch];
							unit = ctl[fcdma_pkg::CTL_WORD] ? 32'd4 : 32'd2;
							ss = ctl[8:7];
							ds = ctl[6:5];
							rsp.source_address = s;
							rsp.dest_address = d;
							rsp.word_unit = ctl[fcdma_pkg::CTL_WORD];
							if (ss == fcdma_pkg::STEP_UP) s = s + unit;
							else if (ss == fcdma_pkg::STEP_DOWN) s = s - unit;
							if (ds == fcdma_pkg::STEP_UP || ds == fcdma_pkg::STEP_NOWB) d = d + unit;
							else if (ds == fcdma_pkg::STEP_DOWN) d = d - unit;
							if (lft != '0) lft = lft - 17'd1;
							cur_src_d = s;
							cur_dst_d = d;
							left_d = lft;
							if (lft == '0) begin
								rsp.last_unit = 1'b1;
								rsp.irq_raise = ctl[fcdma_pkg::CTL_IRQ];
								if (ds != fcdma_pkg::STEP_NOWB) dst_d[ch] = d;
								if (!ctl[fcdma_pkg::CTL_REPEAT]) begin
									ctl_d[ch][fcdma_pkg::CTL_ENABLE] = 1'b0;
									imm_done_d[ch] = 1'b0;
									if (ch == 2'd1) latched_d[0] = 1'b0;
									if (ch == 2'd2) latched_d[1] = 1'b0;
								end
								act_d = 1'b0;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// hold channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				src_q[i] <= '0; dst_q[i] <= '0; cnt_q[i] <= '0; ctl_q[i] <= '0;
			end
			for (int i = 0; i < 2; i++) begin
				fptr_q[i] <= '0; fleft_q[i] <= '0;
			end
			imm_done_q <= '0; latched_q <= '0; pend_q <= '0;
			act_q <= 1'b0; ach_q <= '0;
			cur_src_q <= '0; cur_dst_q <= '0; left_q <= '0;
		end else begin
			for (int i = 0; i < 4; i++) begin
				src_q[i] <= src_d[i]; dst_q[i] <= dst_d[i]; ctl_q[i] <= ctl_d[i];
			end
			if (go && req.command == fcdma_pkg::CMD_WRITE
					&& req.register_sel == fcdma_pkg::REG_CNT)
				cnt_q[req.channel_sel] <= req.write_value[15:0];
			for (int i = 0; i < 2; i++) begin
				fptr_q[i] <= fptr_d[i]; fleft_q[i] <= fleft_d[i];
			end
			imm_done_q <= imm_done_d; latched_q <= latched_d; pend_q <= pend_d;
			act_q <= act_d; ach_q <= ach_d;
			cur_src_q <= cur_src_d; cur_dst_q <= cur_dst_d; left_q <= left_d;
		end
	end

	// channel in service is never also pending
	a_act_not_pend: assert property (@(posedge clk) disable iff (!arst_n)
		act_q |-> !pend_q[ach_q]) else $error("active channel pending");
	// a burst counter stays within the burst
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		fleft_q[0] <= fcdma_pkg::BurstW'(fcdma_pkg::FIFO_BURST_WORDS)
		&& fleft_q[1] <= fcdma_pkg::BurstW'(fcdma_pkg::FIFO_BURST_WORDS))
		else $error("burst overflow");
	// a tick with work always answers
	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(go && req.command == fcdma_pkg::CMD_TICK && (act_q || pend_q != 4'd0)) |-> has_rsp)
		else $error("tick lost");
endmodule
